// ===== rtl/ohlr_pkg.sv =====
// Shared constants, types and codes for the horizon line redraw block.
`default_nettype none

package ohlr_pkg;

  // Offsets run from -HALF_SPAN to +HALF_SPAN.
  localparam int HALF_SPAN = 9;
  localparam int K_W = $clog2(HALF_SPAN + 1) + 1;

  localparam int CENTRE_W = 16;
  localparam int ROLL_W = 8;
  localparam int STEP_W = 8;
  localparam int ADDR_W = 9;
  localparam int CHAR_W = 8;

  localparam int CENTRE_BASE = 2834;
  localparam int GRID_COLS = 30;
  localparam int BARS_PER_ROW = 17;
  localparam int COL_OFFSET = 44;
  localparam int ADDR_LIMIT = 480;

  // Largest row whose block base stays below the address limit.
  localparam int ROW_MAX = ((ADDR_LIMIT - COL_OFFSET + GRID_COLS - 1) / GRID_COLS)
                           * BARS_PER_ROW - 1;

  // Numerator width: unsigned centre plus or minus the slope term, signed.
  localparam int NUM_W = CENTRE_W + 2;
  localparam int MAG_W = NUM_W - 1;

  // Divide by 30 through a reciprocal; exact for numerators below 74898, which covers
  // the largest centre plus the largest slope term.
  localparam int DIV30_SHIFT = 21;
  localparam int DIV30_RECIP = (2 ** DIV30_SHIFT + GRID_COLS - 1) / GRID_COLS;
  localparam int ROWF_W = MAG_W + 18 - DIV30_SHIFT;

  // Divide by 17 through a reciprocal; exact for rows below 256.
  localparam int DIV17_SHIFT = 12;
  localparam int DIV17_RECIP = (2 ** DIV17_SHIFT + BARS_PER_ROW - 1) / BARS_PER_ROW;
  localparam int BLK_W = 4;
  localparam int BAR_W = 5;

  localparam int MARK_ROW = CENTRE_BASE / GRID_COLS;
  localparam int MARK_ADDR = GRID_COLS * (MARK_ROW / BARS_PER_ROW)
                             + (CENTRE_BASE % GRID_COLS) + GRID_COLS;

  localparam logic [CHAR_W-1:0] GLYPH_BAR = 8'h80;
  localparam logic [CHAR_W-1:0] GLYPH_CENTRE = 8'hC0;
  localparam logic [CHAR_W-1:0] GLYPH_WING = 8'hC2;
  localparam logic [CHAR_W-1:0] GLYPH_BLANK = 8'h00;

  // Slots of the centre mark, held in the offset field during the mark phase.
  localparam logic signed [K_W-1:0] MARK_CENTRE = K_W'(0);
  localparam logic signed [K_W-1:0] MARK_LEFT = K_W'(1);
  localparam logic signed [K_W-1:0] MARK_RIGHT = K_W'(2);

  localparam logic signed [K_W-1:0] K_FIRST = -K_W'(HALF_SPAN);
  localparam logic signed [K_W-1:0] K_LAST = K_W'(HALF_SPAN);

  typedef enum logic [1:0] {
    KIND_ERASE,
    KIND_DRAW,
    KIND_MARK
  } kind_e;

  // One candidate write as issued by the sequencer.
  typedef struct packed {
    kind_e                       kind;
    logic signed [K_W-1:0]       k;
    logic [CENTRE_W-1:0]         centre;
    logic signed [ROLL_W-1:0]    roll;
  } cand_t;

endpackage

`default_nettype wire

// ===== rtl/ohlr_seq.sv =====
// Input buffer, line state and the sequencer that issues one candidate write per cycle while the pipeline advances.
`default_nettype none

module ohlr_seq import ohlr_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [STEP_W-1:0] pitch_step_i,
  input  wire logic signed [ROLL_W-1:0] roll_i,
  input  wire logic                     adv_i,
  output logic                          cand_valid_o,
  output cand_t                         cand_o
);

  logic                     hold_valid_q, hold_valid_d;
  logic [CENTRE_W-1:0]      hold_centre_q;
  logic signed [ROLL_W-1:0] hold_roll_q;

  logic                     busy_q, busy_d;
  kind_e                    kind_q, kind_d;
  logic signed [K_W-1:0]    k_q, k_d;

  logic [CENTRE_W-1:0]      ers_centre_q, drw_centre_q, prev_centre_q;
  logic signed [ROLL_W-1:0] ers_roll_q, drw_roll_q, prev_roll_q;

  logic                     in_xfer;
  logic                     issue;
  logic                     final_slot;
  logic                     load;
  logic [CENTRE_W-1:0]      step_ext;
  logic [CENTRE_W-1:0]      centre_new;

  assign in_ready_o = !hold_valid_q;
  assign in_xfer = in_valid_i && in_ready_o;

  // The centre wraps modulo 2^16, so an unsigned product of the width suffices.
  assign step_ext = CENTRE_W'(pitch_step_i);
  assign centre_new = CENTRE_W'(CENTRE_BASE) + CENTRE_W'(step_ext * CENTRE_W'(GRID_COLS));

  assign issue = busy_q && adv_i;
  assign final_slot = (kind_q == KIND_MARK) && (k_q == MARK_RIGHT);
  assign load = hold_valid_q && (!busy_q || (issue && final_slot));
  assign hold_valid_d = (hold_valid_q && !load) || in_xfer;

  always_comb begin
    busy_d = busy_q;
    kind_d = kind_q;
    k_d = k_q;
    if (load) begin
      busy_d = 1'b1;
      kind_d = KIND_ERASE;
      k_d = K_FIRST;
    end else if (issue) begin
      case (kind_q)
        KIND_ERASE: begin
          if (k_q == K_LAST) begin
            kind_d = KIND_DRAW;
            k_d = K_FIRST;
          end else begin
            k_d = k_q + K_W'(1);
          end
        end
        KIND_DRAW: begin
          if (k_q == K_LAST) begin
            kind_d = KIND_MARK;
            k_d = MARK_CENTRE;
          end else begin
            k_d = k_q + K_W'(1);
          end
        end
        KIND_MARK: begin
          if (final_slot) begin
            busy_d = 1'b0;
          end else begin
            k_d = k_q + K_W'(1);
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      busy_q <= 1'b0;
      kind_q <= KIND_ERASE;
      k_q <= K_FIRST;
      prev_centre_q <= CENTRE_W'(CENTRE_BASE);
      prev_roll_q <= '0;
    end else begin
      hold_valid_q <= hold_valid_d;
      busy_q <= busy_d;
      kind_q <= kind_d;
      k_q <= k_d;
      if (load) begin
        prev_centre_q <= hold_centre_q;
        prev_roll_q <= hold_roll_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hold_centre_q <= centre_new;
      hold_roll_q <= roll_i;
    end
    if (load) begin
      // The erase pass works from the line drawn by the previous item.
      ers_centre_q <= prev_centre_q;
      ers_roll_q <= prev_roll_q;
      drw_centre_q <= hold_centre_q;
      drw_roll_q <= hold_roll_q;
    end
  end

  assign cand_valid_o = busy_q;

  always_comb begin
    cand_o.kind = kind_q;
    cand_o.k = k_q;
    if (kind_q == KIND_ERASE) begin
      cand_o.centre = ers_centre_q;
      cand_o.roll = ers_roll_q;
    end else begin
      cand_o.centre = drw_centre_q;
      cand_o.roll = drw_roll_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/osd_horizon_line_redraw.sv =====
// Top level of the horizon line redraw: sequencer plus a three-stage write pipeline.
// Each item issues 4*HALF_SPAN+5 candidate writes, one per cycle while the output is not stalled;
// the sequencer slot count sets the rate, and skipped cells leave empty cycles.
// The first write of an item passes through the stage 1, stage 2 and output registers before it appears.
// A new item is buffered while the previous run is still in progress.
// Reset empties the pipeline and restores the stored line to centre 2834 and roll 0.
`default_nettype none

module osd_horizon_line_redraw import ohlr_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [STEP_W-1:0] pitch_step_i,
  input  wire logic signed [ROLL_W-1:0] roll_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [ADDR_W-1:0]             address_o,
  output logic [CHAR_W-1:0]             character_o,
  output logic                          last_o
);

  localparam logic signed [NUM_W-1:0] NUM_LOW = -NUM_W'(GRID_COLS - 1);

  logic  adv;
  logic  cand_valid;
  cand_t cand;

  // Stage 1: numerator.
  logic signed [K_W+ROLL_W-1:0] prod;
  logic signed [NUM_W-1:0]      prod_x;
  logic signed [NUM_W-1:0]      num_d;
  logic                         s1_valid_q;
  kind_e                        s1_kind_q;
  logic signed [K_W-1:0]        s1_k_q;
  logic signed [NUM_W-1:0]      s1_num_q;

  // Stage 2: row and range checks.
  logic [MAG_W+17:0]            div_prod;
  logic [ROWF_W-1:0]            row_full;
  logic                         skip_d;
  logic [7:0]                   row_d;
  logic                         s2_valid_q;
  logic                         s2_skip_q;
  kind_e                        s2_kind_q;
  logic signed [K_W-1:0]        s2_k_q;
  logic [7:0]                   s2_row_q;

  // Stage 3: cell address and glyph.
  logic [16:0]                  blk_prod;
  logic [BLK_W-1:0]             blk;
  logic [BAR_W-1:0]             bar;
  logic [ADDR_W-1:0]            addr_d;
  logic [CHAR_W-1:0]            char_d;
  logic                         last_d;
  logic                         out_valid_q;
  logic [ADDR_W-1:0]            address_q;
  logic [CHAR_W-1:0]            character_q;
  logic                         last_q;

  // The whole pipeline moves whenever the output register can take a transfer.
  assign adv = !out_valid_q || out_ready_i;

  ohlr_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pitch_step_i (pitch_step_i),
    .roll_i       (roll_i),
    .adv_i        (adv),
    .cand_valid_o (cand_valid),
    .cand_o       (cand)
  );

  assign prod = cand.k * cand.roll;
  assign prod_x = NUM_W'(prod);
  assign num_d = $signed({{(NUM_W - CENTRE_W){1'b0}}, cand.centre})
                 - (prod_x + (prod_x <<< 1));

  // A negative numerator above -30 truncates to row zero; below that the row is negative.
  assign div_prod = {18'b0, s1_num_q[MAG_W-1:0]} * (MAG_W + 18)'(DIV30_RECIP);
  assign row_full = div_prod[DIV30_SHIFT +: ROWF_W];

  always_comb begin
    skip_d = 1'b0;
    row_d = '0;
    if (s1_kind_q != KIND_MARK) begin
      if (s1_num_q[NUM_W-1]) begin
        skip_d = (s1_num_q < NUM_LOW);
      end else begin
        skip_d = (row_full > ROWF_W'(ROW_MAX));
        row_d = row_full[7:0];
      end
    end
  end

  assign blk_prod = {9'b0, s2_row_q} * 17'(DIV17_RECIP);
  assign blk = blk_prod[DIV17_SHIFT +: BLK_W];
  assign bar = BAR_W'(s2_row_q - 8'(blk * 8'(BARS_PER_ROW)));

  always_comb begin
    addr_d = ADDR_W'(blk * ADDR_W'(GRID_COLS)) + ADDR_W'(COL_OFFSET)
             + ADDR_W'(s2_k_q);
    char_d = GLYPH_BLANK;
    last_d = 1'b0;
    case (s2_kind_q)
      KIND_ERASE: begin
        char_d = GLYPH_BLANK;
      end
      KIND_DRAW: begin
        char_d = GLYPH_BAR + CHAR_W'(bar);
      end
      KIND_MARK: begin
        if (s2_k_q == MARK_CENTRE) begin
          addr_d = ADDR_W'(MARK_ADDR);
          char_d = GLYPH_CENTRE;
        end else if (s2_k_q == MARK_LEFT) begin
          addr_d = ADDR_W'(MARK_ADDR - 1);
          char_d = GLYPH_WING;
        end else begin
          addr_d = ADDR_W'(MARK_ADDR + 1);
          char_d = GLYPH_WING;
          last_d = 1'b1;
        end
      end
      default: begin
        char_d = GLYPH_BLANK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= cand_valid;
      s2_valid_q <= s1_valid_q;
      out_valid_q <= s2_valid_q && !s2_skip_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q <= cand.kind;
      s1_k_q <= cand.k;
      s1_num_q <= num_d;
      s2_kind_q <= s1_kind_q;
      s2_k_q <= s1_k_q;
      s2_skip_q <= skip_d;
      s2_row_q <= row_d;
      address_q <= addr_d;
      character_q <= char_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign address_o = address_q;
  assign character_o = character_q;
  assign last_o = last_q;

endmodule

`default_nettype wire
